// ----- src/rgbw_pkg.sv -----
// Shared types and constants for the RGBW timed crossfade engine.
// Used by rgbw_lane, rgbw_merge and rgbw_timed_crossfade; no dependencies.
package rgbw_pkg;

    localparam int LVL_W      = 8;
    localparam int CNT_W      = 22;
    localparam int DUR_W      = 12;
    localparam int DIV_BITS   = CNT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);
    localparam int REPORT_CH  = 4;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [LVL_W-1:0] LEVEL_MAX = {LVL_W{1'b1}};
    localparam logic [9:0]       MS_PER_S  = 10'd1000;

    // Request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_FADE = 2'd1;
    localparam logic [1:0] REQ_SET  = 2'd2;

    // Step direction codes
    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic [LVL_W-1:0] white;
        logic [DUR_W-1:0] duration_s;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
        logic [LVL_W-1:0] white_level;
        logic             done_res;
    } t_out_item;

    // Commands broadcast from the sequencer to every lane
    typedef struct packed {
        logic tick;
        logic set;
        logic fade_start;
        logic div_step;
        logic div_last;
    } t_lane_cmd;

endpackage

// ----- src/rgbw_lane.sv -----
// One color channel: level, target, step timer and a bit-serial interval divider.
// Depends on rgbw_pkg.
module rgbw_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rgbw_pkg::t_lane_cmd      i_cmd,
    input  logic [rgbw_pkg::LVL_W-1:0] i_value,
    input  logic [rgbw_pkg::CNT_W-1:0] i_dur,
    output logic [rgbw_pkg::LVL_W-1:0] o_level,
    output logic                     o_match
);
    import rgbw_pkg::*;

    logic [LVL_W-1:0] r_level, n_level;
    logic [LVL_W-1:0] r_target, n_target;
    logic [1:0]       r_dir, n_dir;
    logic [CNT_W-1:0] r_interval, n_interval;
    logic [CNT_W-1:0] r_elapsed, n_elapsed;
    logic [LVL_W-1:0] r_mag, n_mag;
    logic [LVL_W-1:0] r_rem, n_rem;

    logic [CNT_W-1:0] elapsed_inc;
    logic [LVL_W:0]   rem_trial;
    logic             q_bit;

    assign elapsed_inc = (r_elapsed != CNT_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign rem_trial   = {r_rem, r_interval[CNT_W-1]};
    assign q_bit       = (rem_trial >= {1'b0, r_mag});

    // Next state per command; commands never overlap
    always_comb begin
        n_level    = r_level;
        n_target   = r_target;
        n_dir      = r_dir;
        n_interval = r_interval;
        n_elapsed  = r_elapsed;
        n_mag      = r_mag;
        n_rem      = r_rem;
        if (i_cmd.tick) begin
            n_elapsed = elapsed_inc;
            if (r_level != r_target && elapsed_inc >= r_interval) begin
                case (r_dir)
                    DIR_UP: begin
                        if (r_level != LEVEL_MAX) n_level = r_level + 1'b1;
                    end
                    DIR_DOWN: begin
                        if (r_level != '0) n_level = r_level - 1'b1;
                    end
                    default: n_level = r_level;
                endcase
                n_elapsed = '0;
            end
        end else if (i_cmd.set) begin
            n_level  = i_value;
            n_target = i_value;
        end else if (i_cmd.fade_start) begin
            n_target   = i_value;
            n_interval = i_dur;
            n_rem      = '0;
            if (i_value > r_level) begin
                n_dir = DIR_UP;
                n_mag = i_value - r_level;
            end else if (i_value < r_level) begin
                n_dir = DIR_DOWN;
                n_mag = r_level - i_value;
            end else begin
                n_dir = DIR_HOLD;
                n_mag = '0;
            end
        end else if (i_cmd.div_step) begin
            // Restoring division, quotient shifts into the interval register
            n_rem      = q_bit ? LVL_W'(rem_trial - {1'b0, r_mag}) : rem_trial[LVL_W-1:0];
            n_interval = {r_interval[CNT_W-2:0], q_bit};
            if (i_cmd.div_last && r_mag == '0) n_interval = '0;
        end
    end

    // Channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= '0;
            r_target   <= '0;
            r_dir      <= DIR_HOLD;
            r_interval <= '0;
            r_elapsed  <= '0;
        end else begin
            r_level    <= n_level;
            r_target   <= n_target;
            r_dir      <= n_dir;
            r_interval <= n_interval;
            r_elapsed  <= n_elapsed;
        end
    end

    // Divider working registers
    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_rem <= n_rem;
    end

    assign o_level = r_level;
    assign o_match = (r_level == r_target);

endmodule

// ----- src/rgbw_merge.sv -----
// Merge stage: reduces lane matches into the done flag and holds the result register.
// Depends on rgbw_pkg.
module rgbw_merge #(
    parameter int CHANNELS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [CHANNELS-1:0][rgbw_pkg::LVL_W-1:0] i_levels,
    input  logic [CHANNELS-1:0]                    i_match,
    input  logic                                   i_upd,
    input  logic                                   i_load,
    output logic                                   o_free,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output rgbw_pkg::t_out_item                    o_out_data
);
    import rgbw_pkg::*;

    logic                  r_all_reached, n_all_reached;
    logic                  r_valid;
    t_out_item             r_data;
    logic [REPORT_CH-1:0][LVL_W-1:0] rep_level;

    // Report the four color channels; absent lanes read as zero
    for (genvar c = 0; c < REPORT_CH; c++) begin : g_rep
        if (c < CHANNELS) begin : g_have
            assign rep_level[c] = i_levels[c];
        end else begin : g_none
            assign rep_level[c] = '0;
        end
    end

    assign n_all_reached = i_upd ? (&i_match) : r_all_reached;
    assign o_free        = !r_valid || i_out_ready;

    // Track completion after each tick and the valid flag of the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_reached <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_all_reached <= n_all_reached;
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Capture the result transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.red_level   <= rep_level[0];
            r_data.green_level <= rep_level[1];
            r_data.blue_level  <= rep_level[2];
            r_data.white_level <= rep_level[3];
            r_data.done_res    <= n_all_reached;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ----- src/rgbw_timed_crossfade.sv -----
// Top level of the RGBW timed crossfade engine: request sequencer, lanes, merge.
// Depends on rgbw_pkg, rgbw_lane and rgbw_merge.
//
// One request is handled at a time and each gives one result transaction.
// A tick, a set or an unknown request passes through the execute state, which
// updates the lanes for a tick or a set, and the response state, which loads
// the result. A fade passes through execute, which forms duration_s*1000, start,
// which loads the lanes, divide, where the one-bit-per-cycle divider that every
// lane carries finds its step interval (all lanes divide in parallel), and
// response, which loads the result. Input ready returns when the result is
// loaded, so a new request is taken only once the previous one is through. The
// next request is taken even while the previous result still waits for the
// consumer; a result that the consumer does not take holds the sequencer in its
// last state.
// No clearing pass after reset.
module rgbw_timed_crossfade #(
    parameter int CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rgbw_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rgbw_pkg::t_out_item o_out_data
);
    import rgbw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_in_item             r_item;
    logic [CNT_W-1:0]     r_dur;

    t_lane_cmd                       lane_cmd;
    logic [CHANNELS-1:0][LVL_W-1:0] lane_value;
    logic [CHANNELS-1:0][LVL_W-1:0] lane_level;
    logic [CHANNELS-1:0]            lane_match;
    logic                            in_fire;
    logic                            merge_free;
    logic                            res_load;
    logic                            res_upd;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign res_load   = (r_state == S_RESP) && merge_free;
    assign res_upd    = (r_state == S_RESP) && (r_item.req_type == REQ_TICK);

    // Sequence one request
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_EXEC;
            S_EXEC:  n_state = (r_item.req_type == REQ_FADE) ? S_START : S_RESP;
            S_START: n_state = S_DIV;
            S_DIV:   if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) n_state = S_RESP;
            S_RESP:  if (merge_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Hold the accepted transaction and the fade duration in milliseconds
    always_ff @(posedge i_clk) begin
        if (in_fire) r_item <= i_in_data;
        if (r_state == S_EXEC) begin
            r_dur <= CNT_W'(r_item.duration_s) * CNT_W'(MS_PER_S);
        end
    end

    // Broadcast lane commands
    always_comb begin
        lane_cmd            = '0;
        lane_cmd.tick       = (r_state == S_EXEC) && (r_item.req_type == REQ_TICK);
        lane_cmd.set        = (r_state == S_EXEC) && (r_item.req_type == REQ_SET);
        lane_cmd.fade_start = (r_state == S_START);
        lane_cmd.div_step   = (r_state == S_DIV);
        lane_cmd.div_last   = (r_state == S_DIV) && (r_cnt == DIV_CNT_W'(DIV_BITS - 1));
    end

    // Lanes: four color channels, extra lanes take zero
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        if (c == 0) begin : g_red
            assign lane_value[c] = r_item.red;
        end else if (c == 1) begin : g_green
            assign lane_value[c] = r_item.green;
        end else if (c == 2) begin : g_blue
            assign lane_value[c] = r_item.blue;
        end else if (c == 3) begin : g_white
            assign lane_value[c] = r_item.white;
        end else begin : g_zero
            assign lane_value[c] = '0;
        end

        rgbw_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd),
            .i_value (lane_value[c]),
            .i_dur   (r_dur),
            .o_level (lane_level[c]),
            .o_match (lane_match[c])
        );
    end

    rgbw_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_levels    (lane_level),
        .i_match     (lane_match),
        .i_upd       (res_upd),
        .i_load      (res_load),
        .o_free      (merge_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < DIV_CNT_W'(DIV_BITS)))
        else $error("divider step count out of range");

    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> (r_state == S_DIV))
        else $error("fade start not followed by division");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result loaded outside the response state");
`endif

endmodule
